[rtl/hvc_pkg.sv]
// ----------------------------------------------------------------------------
// hvc_pkg
// Shared constants, types and codes for the hash table value counter.
// ----------------------------------------------------------------------------
`default_nettype none

package hvc_pkg;

  localparam int TABLE_SLOTS = 1024;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int OCC_W       = SLOT_W + 1;
  localparam int KEY_W       = 64;
  localparam int COUNT_BITS  = 32;
  localparam int WORD_W      = 1 + KEY_W + COUNT_BITS;
  localparam int HALF_SLOTS  = TABLE_SLOTS / 2;

  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_COUNTED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_SKIPPED  = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_HALTED   = 3'd4,
    ST_READ     = 3'd5
  } status_t;

  // One item handed from the front to the back
  typedef struct packed {
    logic              opcode;
    logic              present;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] start;
    logic [SLOT_W-1:0] idx;
  } hvc_item_t;

  // One result as built by the back
  typedef struct packed {
    status_t               status;
    logic                  occupied;
    logic [KEY_W-1:0]      key;
    logic [COUNT_BITS-1:0] count;
    logic [SLOT_W-1:0]     pos;
    logic [OCC_W-1:0]      probes;
  } hvc_result_t;

endpackage

`default_nettype wire

[rtl/hash_table_value_counter.sv]
// The front hashes each count item with six 32x32 multiply steps of fmix64
//   and takes no new item until it has pushed the last into the queue. The
//   back takes one item at a time and probes P slots for it, one table read
//   per probe (P = 1 for a read, 0 for a skipped or halted item).
// Reset: synchronous, active low; a clearing pass wipes all 1024 slots of the
//   table, and no item is accepted until it ends.
// ----------------------------------------------------------------------------
// hash_table_value_counter
// Counts 64-bit values in a linear-probing hash table of 1024 slots.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_table_value_counter (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic               cfg_data,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic               in_opcode,
  input  wire logic signed [63:0] in_value,
  input  wire logic               in_present,
  input  wire logic [9:0]         in_slot_index,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [2:0]         out_status,
  output      logic               out_slot_occupied,
  output      logic signed [63:0] out_slot_key,
  output      logic [31:0]        out_slot_count,
  output      logic [9:0]         out_slot_position,
  output      logic [10:0]        out_probe_count,
  output      logic [10:0]        out_occupancy
);
  import hvc_pkg::*;

  logic      narrow_r;
  logic      busy;
  logic      f_ready;
  logic      fq_valid, fq_ready;
  hvc_item_t fq_item;
  logic      qb_valid, qb_ready;
  hvc_item_t qb_item;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      narrow_r <= 1'b0;
    end else if (cfg_valid) begin
      narrow_r <= cfg_data;
    end
  end

  // Hold input while the table is being cleared
  assign in_ready = f_ready && !busy;

  hvc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .narrow_keys   (narrow_r),
    .in_valid      (in_valid && !busy),
    .in_ready      (f_ready),
    .in_opcode     (in_opcode),
    .in_value      (in_value),
    .in_present    (in_present),
    .in_slot_index (in_slot_index),
    .q_valid       (fq_valid),
    .q_ready       (fq_ready),
    .q_item        (fq_item)
  );

  hvc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_item  (qb_item)
  );

  hvc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .busy              (busy),
    .q_valid           (qb_valid),
    .q_ready           (qb_ready),
    .q_item            (qb_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_slot_occupied (out_slot_occupied),
    .out_slot_key      (out_slot_key),
    .out_slot_count    (out_slot_count),
    .out_slot_position (out_slot_position),
    .out_probe_count   (out_probe_count),
    .out_occupancy     (out_occupancy)
  );

endmodule

`default_nettype wire

[rtl/hvc_ram.sv]
// ----------------------------------------------------------------------------
// hvc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/hvc_front.sv]
// ----------------------------------------------------------------------------
// hvc_front
// Accepts items, widens narrow keys and hashes count keys with fmix64.
// Each 64x64 multiply runs as three 32x32 partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module hvc_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               narrow_keys,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic               in_opcode,
  input  wire logic signed [63:0] in_value,
  input  wire logic               in_present,
  input  wire logic [9:0]         in_slot_index,
  output      logic               q_valid,
  input  wire logic               q_ready,
  output      hvc_pkg::hvc_item_t q_item
);
  import hvc_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_HASH = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t           state_r, state_nxt;
  logic [1:0]        step_r, step_nxt;
  logic              pass_r, pass_nxt;
  logic [63:0]       a_r, a_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic              op_r, op_nxt;
  logic              pres_r, pres_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [SLOT_W-1:0] start_r, start_nxt;

  logic [63:0] in_key;
  logic [63:0] mix_c;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] sum;
  logic [63:0] mixed;

  // Sign-extend the low half in narrow mode
  assign in_key = narrow_keys ? {{32{in_value[31]}}, in_value[31:0]} : in_value;

  // Partial product select: lo*lo, lo*hi, hi*lo
  always_comb begin
    mix_c = pass_r ? MIX_C2 : MIX_C1;
    mul_a = (step_r == 2'd2) ? a_r[63:32] : a_r[31:0];
    mul_b = (step_r == 2'd1) ? mix_c[63:32] : mix_c[31:0];
    prod  = 64'(mul_a) * 64'(mul_b);
    sum   = acc_r + {prod[31:0], 32'd0};
    mixed = sum ^ (sum >> 33);
  end

  assign in_ready = (state_r == F_IDLE);
  assign q_valid  = (state_r == F_PUSH);
  assign q_item   = '{opcode: op_r, present: pres_r, key: key_r, start: start_r, idx: idx_r};

  // Sequence accept, hash and push
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    pass_nxt  = pass_r;
    a_nxt     = a_r;
    acc_nxt   = acc_r;
    key_nxt   = key_r;
    op_nxt    = op_r;
    pres_nxt  = pres_r;
    idx_nxt   = idx_r;
    start_nxt = start_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          key_nxt   = in_key;
          op_nxt    = in_opcode;
          pres_nxt  = in_present;
          idx_nxt   = in_slot_index;
          start_nxt = '0;
          a_nxt     = in_key ^ (in_key >> 33);
          step_nxt  = 2'd0;
          pass_nxt  = 1'b0;
          state_nxt = (in_opcode == OP_COUNT && in_present) ? F_HASH : F_PUSH;
        end
      end
      F_HASH: begin
        case (step_r)
          2'd0: begin
            acc_nxt  = prod;
            step_nxt = 2'd1;
          end
          2'd1: begin
            acc_nxt  = sum;
            step_nxt = 2'd2;
          end
          default: begin
            step_nxt = 2'd0;
            if (!pass_r) begin
              a_nxt    = mixed;
              pass_nxt = 1'b1;
            end else begin
              start_nxt = mixed[SLOT_W-1:0];
              state_nxt = F_PUSH;
            end
          end
        endcase
      end
      F_PUSH: begin
        if (q_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    pass_r  <= pass_nxt;
    a_r     <= a_nxt;
    acc_r   <= acc_nxt;
    key_r   <= key_nxt;
    op_r    <= op_nxt;
    pres_r  <= pres_nxt;
    idx_r   <= idx_nxt;
    start_r <= start_nxt;
  end

endmodule

`default_nettype wire

[rtl/hvc_queue.sv]
// ----------------------------------------------------------------------------
// hvc_queue
// Two-entry queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module hvc_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_valid,
  output      logic               wr_ready,
  input  wire hvc_pkg::hvc_item_t wr_item,
  output      logic               rd_valid,
  input  wire logic               rd_ready,
  output      hvc_pkg::hvc_item_t rd_item
);
  import hvc_pkg::*;

  hvc_item_t  ent_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = ent_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Advance pointers and fill level
  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store a beat
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

[rtl/hvc_back.sv]
// ----------------------------------------------------------------------------
// hvc_back
// Probes the slot table one read per cycle, updates counts and inserts
// keys, and holds each result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hvc_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  output      logic                          busy,
  input  wire logic                          q_valid,
  output      logic                          q_ready,
  input  wire hvc_pkg::hvc_item_t            q_item,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [2:0]                    out_status,
  output      logic                          out_slot_occupied,
  output      logic signed [63:0]            out_slot_key,
  output      logic [31:0]                   out_slot_count,
  output      logic [9:0]                    out_slot_position,
  output      logic [10:0]                   out_probe_count,
  output      logic [10:0]                   out_occupancy
);
  import hvc_pkg::*;

  typedef enum logic [3:0] {
    B_CLEAR = 4'b0001,
    B_IDLE  = 4'b0010,
    B_CHK   = 4'b0100,
    B_EMIT  = 4'b1000
  } bstate_t;

  bstate_t           state_r, state_nxt;
  logic [SLOT_W-1:0] clr_r, clr_nxt;
  hvc_item_t         it_r, it_nxt;
  logic [SLOT_W-1:0] pos_r, pos_nxt;
  logic [OCC_W-1:0]  probes_r, probes_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic              halted_r, halted_nxt;
  hvc_result_t       res_r, res_nxt;

  logic              out_valid_r, out_valid_nxt;
  hvc_result_t       out_res_r;
  logic [OCC_W-1:0]  out_occ_r;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic                  d_valid;
  logic [KEY_W-1:0]      d_key;
  logic [COUNT_BITS-1:0] d_cnt;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [OCC_W-1:0]      occ_inc;
  logic                  load_out;

  hvc_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_SLOTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign {d_valid, d_key, d_cnt} = ram_rdata;
  assign cnt_inc  = (d_cnt == '1) ? d_cnt : d_cnt + 1'b1;
  assign occ_inc  = occ_r + 1'b1;
  assign busy     = (state_r == B_CLEAR);
  assign q_ready  = (state_r == B_IDLE);
  assign load_out = (state_r == B_EMIT) && (!out_valid_r || out_ready);

  // Probe sequencer
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    it_nxt     = it_r;
    pos_nxt    = pos_r;
    probes_nxt = probes_r;
    occ_nxt    = occ_r;
    halted_nxt = halted_r;
    res_nxt    = res_r;
    ram_we     = 1'b0;
    ram_waddr  = pos_r;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = pos_r;
    case (state_r)
      B_CLEAR: begin
        // Wipe one slot per cycle after reset
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_valid) begin
          it_nxt     = q_item;
          res_nxt    = '{status: ST_SKIPPED, occupied: 1'b0, key: '0, count: '0,
                         pos: '0, probes: '0};
          probes_nxt = OCC_W'(1);
          if (q_item.opcode == OP_READ) begin
            pos_nxt   = q_item.idx;
            ram_re    = 1'b1;
            ram_raddr = q_item.idx;
            state_nxt = B_CHK;
          end else if (halted_r) begin
            res_nxt.status = ST_HALTED;
            state_nxt      = B_EMIT;
          end else if (!q_item.present) begin
            state_nxt = B_EMIT;
          end else begin
            pos_nxt   = q_item.start;
            ram_re    = 1'b1;
            ram_raddr = q_item.start;
            state_nxt = B_CHK;
          end
        end
      end
      B_CHK: begin
        if (it_r.opcode == OP_READ) begin
          res_nxt   = '{status: ST_READ, occupied: d_valid,
                        key: d_valid ? d_key : '0, count: d_valid ? d_cnt : '0,
                        pos: pos_r, probes: '0};
          state_nxt = B_EMIT;
        end else if (!d_valid) begin
          // Empty slot: insert with a count of one
          ram_we     = 1'b1;
          ram_wdata  = {1'b1, it_r.key, COUNT_BITS'(1)};
          occ_nxt    = occ_inc;
          res_nxt    = '{status: ST_INSERTED, occupied: 1'b1, key: it_r.key,
                         count: COUNT_BITS'(1), pos: pos_r, probes: probes_r};
          if (occ_inc > OCC_W'(HALF_SLOTS)) begin
            res_nxt.status = ST_OVERFLOW;
            halted_nxt     = 1'b1;
          end
          state_nxt = B_EMIT;
        end else if (d_key == it_r.key) begin
          // Hit: saturating increment
          ram_we    = 1'b1;
          ram_wdata = {1'b1, d_key, cnt_inc};
          res_nxt   = '{status: ST_COUNTED, occupied: 1'b1, key: d_key, count: cnt_inc,
                        pos: pos_r, probes: probes_r};
          state_nxt = B_EMIT;
        end else if (probes_r == OCC_W'(TABLE_SLOTS)) begin
          res_nxt    = '{status: ST_OVERFLOW, occupied: 1'b0, key: '0, count: '0,
                         pos: '0, probes: OCC_W'(TABLE_SLOTS)};
          halted_nxt = 1'b1;
          state_nxt  = B_EMIT;
        end else begin
          // Advance to the next slot, wrapping at the end
          pos_nxt    = pos_r + 1'b1;
          probes_nxt = probes_r + 1'b1;
          ram_re     = 1'b1;
          ram_raddr  = pos_r + 1'b1;
        end
      end
      B_EMIT: begin
        if (load_out) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Output register valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      occ_r       <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      occ_r       <= occ_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r     <= it_nxt;
    pos_r    <= pos_nxt;
    probes_r <= probes_nxt;
    res_r    <= res_nxt;
    if (load_out) begin
      out_res_r <= res_r;
      out_occ_r <= occ_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_slot_occupied = out_res_r.occupied;
  assign out_slot_key      = out_res_r.key;
  assign out_slot_count    = out_res_r.count;
  assign out_slot_position = out_res_r.pos;
  assign out_probe_count   = out_res_r.probes;
  assign out_occupancy     = out_occ_r;

endmodule

`default_nettype wire
